/* rtl/core/skn_pkg.sv */
package skn_pkg;

  localparam int MAX_KEYS = 64;
  localparam int KEY_W    = 32;
  localparam int CNT_W    = 7;
  localparam int IDX_W    = $clog2(MAX_KEYS);

  typedef enum logic [2:0] {
    OP_READ      = 3'd0,
    OP_WRITE     = 3'd1,
    OP_INSERT    = 3'd2,
    OP_REMOVE    = 3'd3,
    OP_SRCH_UP   = 3'd4,
    OP_SRCH_EQ   = 3'd5,
    OP_SRCH_LE   = 3'd6,
    OP_SET_COUNT = 3'd7
  } op_t;

  typedef enum logic {
    ST_IDLE    = 1'b0,
    ST_RESOLVE = 1'b1
  } state_t;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] index;
    logic [CNT_W-1:0] new_count;
  } in_beat_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_out;
    logic [CNT_W-1:0] position;
    logic             error;
    logic [CNT_W-1:0] count;
  } out_beat_t;

  // broadcast to every cell on an accepted beat
  typedef struct packed {
    logic             accept;
    logic             err;
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] index;
    logic [CNT_W-1:0] count;
  } cell_cmd_t;

  // held between accept and result
  typedef struct packed {
    op_t              op;
    logic             err;
    logic [CNT_W-1:0] count;
  } pend_t;

endpackage

/* rtl/core/sorted_key_node_table_top.sv */
// Sorted key array of one tree node plus its key count.
// Input channel (in_valid / in_stall / in_data) carries one command beat:
// opcode, key, index, new_count. Output channel (out_valid / out_stall /
// out_data) returns exactly one result beat per command: key_out, position,
// error, count.
// Keys live in a row of MAX_KEYS cells. On the accept edge every cell
// compares its key with the command key and, for write, insert and remove,
// loads the command key or its left or right neighbor's value, so a shift
// completes on the accept edge. The resolve state then forms the search
// position and read data from the registered cell flags and loads them into
// the output register once it is free. No new command is taken before the
// last one resolves; in_stall is high while a command resolves.
// When the receiver stalls, the result holds in the output register; one
// more command can be accepted, and in_stall stays high after that until the
// held beat is taken.
// Reset clears the key count to zero and empties the output register; key
// cells are not cleared and are only meaningful below the count.
module sorted_key_node_table_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  skn_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output skn_pkg::out_beat_t  out_data
);
  import skn_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_q_next;
  pend_t            pend;
  logic             in_accept;
  logic             err;
  logic             free;
  op_t              op;
  cell_cmd_t        cmd;

  logic [KEY_W-1:0]    key_arr [MAX_KEYS];
  logic [KEY_W-1:0]    rd_arr  [MAX_KEYS];
  logic [MAX_KEYS-1:0] gt_vec;
  logic [MAX_KEYS-1:0] eq_vec;

  assign op        = op_t'(in_data.opcode);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    case (op)
      OP_READ, OP_WRITE, OP_REMOVE: err = (in_data.index >= count_q);
      OP_INSERT: err = (in_data.index > count_q) || (count_q >= CNT_W'(MAX_KEYS));
      OP_SET_COUNT: err = (in_data.new_count > CNT_W'(MAX_KEYS));
      default: err = 1'b0;
    endcase
  end

  always_comb begin
    count_q_next = count_q;
    if (in_accept && !err) begin
      case (op)
        OP_INSERT:    count_q_next = count_q + CNT_W'(1);
        OP_REMOVE:    count_q_next = count_q - CNT_W'(1);
        OP_SET_COUNT: count_q_next = in_data.new_count;
        default:      count_q_next = count_q;
      endcase
    end
  end

  // next state
  always_comb begin
    case (state)
      ST_IDLE:    state_next = in_valid ? ST_RESOLVE : ST_IDLE;
      ST_RESOLVE: state_next = free ? ST_IDLE : ST_RESOLVE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    case (state)
      ST_IDLE: in_stall = 1'b0;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count_q <= '0;
    end else begin
      state   <= state_next;
      count_q <= count_q_next;
    end
    if (in_accept) begin
      pend.op    <= op;
      pend.err   <= err;
      pend.count <= count_q_next;
    end
  end

  assign cmd.accept = in_accept;
  assign cmd.err    = err;
  assign cmd.op     = op;
  assign cmd.key    = in_data.key;
  assign cmd.index  = in_data.index;
  assign cmd.count  = count_q;

  for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
    logic [KEY_W-1:0] left_key;
    logic [KEY_W-1:0] right_key;

    if (g == 0) begin : g_first
      assign left_key = in_data.key;
    end else begin : g_mid_l
      assign left_key = key_arr[g-1];
    end
    if (g == MAX_KEYS - 1) begin : g_last
      assign right_key = '0;
    end else begin : g_mid_r
      assign right_key = key_arr[g+1];
    end

    skn_cell u_cell (
      .clk       (clk),
      .cell_idx  (CNT_W'(g)),
      .cmd       (cmd),
      .left_key  (left_key),
      .right_key (right_key),
      .key_q     (key_arr[g]),
      .gt_q      (gt_vec[g]),
      .eq_q      (eq_vec[g]),
      .rd_q      (rd_arr[g])
    );
  end

  skn_result u_result (
    .clk       (clk),
    .rst       (rst),
    .resolve   (state == ST_RESOLVE),
    .pend      (pend),
    .gt_vec    (gt_vec),
    .eq_vec    (eq_vec),
    .rd_vec    (rd_arr),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count_q <= CNT_W'(MAX_KEYS))
    else $error("key count above node capacity");

  a_accept_resolve: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state == ST_RESOLVE && in_stall)
    else $error("accepted beat not resolving");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    in_accept && op == OP_INSERT && !err |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not raise count");

  a_error_keeps_count: assert property (@(posedge clk) disable iff (rst)
    in_accept && err |=> $stable(count_q))
    else $error("refused command changed count");

endmodule

/* rtl/core/skn_cell.sv */
module skn_cell (
  input  logic                       clk,
  input  logic [skn_pkg::CNT_W-1:0]  cell_idx,
  input  skn_pkg::cell_cmd_t         cmd,
  input  logic [skn_pkg::KEY_W-1:0]  left_key,
  input  logic [skn_pkg::KEY_W-1:0]  right_key,
  output logic [skn_pkg::KEY_W-1:0]  key_q,
  output logic                       gt_q,
  output logic                       eq_q,
  output logic [skn_pkg::KEY_W-1:0]  rd_q
);
  import skn_pkg::*;

  logic [KEY_W-1:0] key_q_next;
  logic             sel;
  logic             in_range;
  logic             ins_shift;
  logic             rem_shift;

  assign sel       = (cell_idx == cmd.index);
  assign in_range  = (cell_idx < cmd.count);
  assign ins_shift = (cell_idx > cmd.index) && (cell_idx <= cmd.count);
  assign rem_shift = (cell_idx >= cmd.index) &&
                     (({1'b0, cell_idx} + (CNT_W+1)'(1)) < {1'b0, cmd.count});

  always_comb begin
    key_q_next = key_q;
    if (cmd.accept && !cmd.err) begin
      case (cmd.op)
        OP_WRITE: begin
          if (sel) key_q_next = cmd.key;
        end
        OP_INSERT: begin
          if (sel) key_q_next = cmd.key;
          else if (ins_shift) key_q_next = left_key;
        end
        OP_REMOVE: begin
          if (rem_shift) key_q_next = right_key;
        end
        default: key_q_next = key_q;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    key_q <= key_q_next;
    if (cmd.accept) begin
      // compare against the pre-update contents
      gt_q <= in_range && (key_q > cmd.key);
      eq_q <= (key_q == cmd.key);
      rd_q <= sel ? key_q : '0;
    end
  end

endmodule

/* rtl/core/skn_result.sv */
module skn_result (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       resolve,
  input  skn_pkg::pend_t             pend,
  input  logic [skn_pkg::MAX_KEYS-1:0] gt_vec,
  input  logic [skn_pkg::MAX_KEYS-1:0] eq_vec,
  input  logic [skn_pkg::KEY_W-1:0]  rd_vec [skn_pkg::MAX_KEYS],
  output logic                       free,
  output logic                       out_valid,
  input  logic                       out_stall,
  output skn_pkg::out_beat_t         out_data
);
  import skn_pkg::*;

  logic [CNT_W-1:0] upos;
  logic [CNT_W-1:0] upos_m1;
  logic             eq_at;
  logic [KEY_W-1:0] rd_or;
  logic [CNT_W-1:0] pos;
  logic             load;
  logic             out_valid_next;

  // first cell above the key, else the count
  always_comb begin
    upos = pend.count;
    for (int i = MAX_KEYS - 1; i >= 0; i--) begin
      if (gt_vec[i]) upos = CNT_W'(i);
    end
  end

  assign upos_m1 = upos - CNT_W'(1);
  assign eq_at   = (upos != '0) && eq_vec[upos_m1[IDX_W-1:0]];

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < MAX_KEYS; i++) begin
      rd_or = rd_or | rd_vec[i];
    end
  end

  always_comb begin
    case (pend.op)
      OP_SRCH_UP: pos = upos;
      OP_SRCH_EQ: pos = eq_at ? upos_m1 : pend.count;
      OP_SRCH_LE: pos = eq_at ? upos_m1 : upos;
      default:    pos = '0;
    endcase
  end

  assign free           = !out_valid || !out_stall;
  assign load           = resolve && free;
  assign out_valid_next = load || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
    if (load) begin
      out_data.key_out  <= (pend.op == OP_READ && !pend.err) ? rd_or : '0;
      out_data.position <= pos;
      out_data.error    <= pend.err;
      out_data.count    <= pend.count;
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

endmodule

/* tb/sorted_key_node_table_checker.sv */
`timescale 1ns / 100ps
module sorted_key_node_table_checker
  import skn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_beat_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_beat_t   out_data,
  output int unsigned fails,
  output int unsigned waiting
);

  logic [KEY_W-1:0] node_keys [MAX_KEYS];
  int               node_cnt;
  out_beat_t        results_due [$];
  int unsigned      nfail = 0;

  // first held slot whose key is above k, or the count when there is none
  function automatic int upper_slot(logic [KEY_W-1:0] k);
    for (int i = 0; i < node_cnt; i++)
      if (node_keys[i] > k) return i;
    return node_cnt;
  endfunction

  function automatic out_beat_t node_step(in_beat_t b);
    out_beat_t r;
    int        idx;
    int        nc;
    int        u;
    r   = '0;
    idx = b.index;
    nc  = b.new_count;
    case (op_t'(b.opcode))
      OP_READ: begin
        if (idx < node_cnt) r.key_out = node_keys[idx];
        else r.error = 1'b1;
      end
      OP_WRITE: begin
        if (idx < node_cnt) node_keys[idx] = b.key;
        else r.error = 1'b1;
      end
      OP_INSERT: begin
        if (idx > node_cnt || node_cnt >= MAX_KEYS) begin
          r.error = 1'b1;
        end else begin
          for (int i = node_cnt; i > idx; i--) node_keys[i] = node_keys[i - 1];
          node_keys[idx] = b.key;
          node_cnt++;
        end
      end
      OP_REMOVE: begin
        if (idx >= node_cnt) begin
          r.error = 1'b1;
        end else begin
          for (int i = idx; i + 1 < node_cnt; i++) node_keys[i] = node_keys[i + 1];
          node_cnt--;
        end
      end
      OP_SRCH_UP: r.position = CNT_W'(upper_slot(b.key));
      OP_SRCH_EQ: begin
        u = upper_slot(b.key);
        r.position = (u > 0 && node_keys[u - 1] == b.key) ? CNT_W'(u - 1) : CNT_W'(node_cnt);
      end
      OP_SRCH_LE: begin
        u = upper_slot(b.key);
        r.position = (u > 0 && node_keys[u - 1] == b.key) ? CNT_W'(u - 1) : CNT_W'(u);
      end
      default: begin
        if (nc > MAX_KEYS) r.error = 1'b1;
        else node_cnt = nc;
      end
    endcase
    r.count = CNT_W'(node_cnt);
    return r;
  endfunction

  function automatic void field_check(string name, logic [KEY_W-1:0] want,
                                      logic [KEY_W-1:0] got);
    if (got !== want) begin
      nfail++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    out_beat_t want;
    if (rst) begin
      node_cnt = 0;
      results_due.delete();
      for (int i = 0; i < MAX_KEYS; i++) node_keys[i] = '0;
    end else begin
      // a result can never leave on the edge its own command arrives
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          nfail++;
          $display("%0t: result beat with nothing expected, expected none, got %h",
                   $time, out_data);
        end else begin
          want = results_due.pop_front();
          field_check("key_out", want.key_out, out_data.key_out);
          field_check("position", KEY_W'(want.position), KEY_W'(out_data.position));
          field_check("error", KEY_W'(want.error), KEY_W'(out_data.error));
          field_check("count", KEY_W'(want.count), KEY_W'(out_data.count));
        end
      end
      if (in_valid && !in_stall) results_due.push_back(node_step(in_data));
    end
    fails   <= nfail;
    waiting <= results_due.size();
  end

endmodule

/* tb/tb_sorted_key_node_table_top.sv */
`timescale 1ns / 100ps
module tb_sorted_key_node_table_top;
  import skn_pkg::*;

  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_BEATS = 925;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_beat_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_beat_t   out_data;
  int unsigned fails;
  int unsigned waiting;
  int unsigned n_sent;
  int unsigned n_got;

  // image of the node on the sending side, used to shape sorted sequences
  // and to keep the count from rising over cells never written
  logic [KEY_W-1:0]    img_keys [MAX_KEYS];
  logic [MAX_KEYS-1:0] img_set;
  int                  img_cnt;
  bit                  grow;

  sorted_key_node_table_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  sorted_key_node_table_checker u_chk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fails     (fails),
    .waiting   (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_beat_t cmd(op_t op, logic [KEY_W-1:0] k, int idx, int nc);
    in_beat_t b;
    b.opcode    = op;
    b.key       = k;
    b.index     = CNT_W'(idx);
    b.new_count = CNT_W'(nc);
    return b;
  endfunction

  function automatic void img_apply(in_beat_t b);
    int idx;
    int nc;
    idx = b.index;
    nc  = b.new_count;
    case (op_t'(b.opcode))
      OP_WRITE: if (idx < img_cnt) img_keys[idx] = b.key;
      OP_INSERT: begin
        if (idx <= img_cnt && img_cnt < MAX_KEYS) begin
          for (int i = img_cnt; i > idx; i--) begin
            img_keys[i] = img_keys[i - 1];
            img_set[i]  = img_set[i - 1];
          end
          img_keys[idx] = b.key;
          img_set[idx]  = 1'b1;
          img_cnt++;
        end
      end
      OP_REMOVE: begin
        if (idx < img_cnt) begin
          for (int i = idx; i + 1 < img_cnt; i++) begin
            img_keys[i] = img_keys[i + 1];
            img_set[i]  = img_set[i + 1];
          end
          img_cnt--;
        end
      end
      OP_SET_COUNT: if (nc <= MAX_KEYS) img_cnt = nc;
      default: ;
    endcase
  endfunction

  function automatic int defined_run();
    int n;
    n = 0;
    while (n < MAX_KEYS && img_set[n]) n++;
    return n;
  endfunction

  function automatic in_beat_t make_beat();
    in_beat_t         b;
    int               r;
    int               idx;
    int               nxt;
    logic [KEY_W-1:0] lo;
    logic [KEY_W-1:0] hi;
    // raw fields stand as noise unless a well-formed command replaces them
    b.opcode    = 3'($urandom);
    b.key       = $urandom;
    b.index     = 7'($urandom);
    b.new_count = 7'($urandom);
    if (grow && img_cnt == MAX_KEYS && $urandom_range(3) == 0) grow = 1'b0;
    else if (!grow && img_cnt <= 1 && $urandom_range(3) == 0) grow = 1'b1;
    r = $urandom_range(99);
    if (r < 92) begin
      if (r < 30)      b.opcode = grow ? OP_INSERT : OP_REMOVE;
      else if (r < 38) b.opcode = grow ? OP_REMOVE : OP_INSERT;
      else if (r < 52) b.opcode = OP_READ;
      else if (r < 62) b.opcode = OP_WRITE;
      else if (r < 71) b.opcode = OP_SRCH_UP;
      else if (r < 80) b.opcode = OP_SRCH_EQ;
      else if (r < 89) b.opcode = OP_SRCH_LE;
      else             b.opcode = OP_SET_COUNT;
      if ($urandom_range(9) != 0) begin
        if (b.opcode == OP_INSERT) b.index = 7'($urandom_range(img_cnt, 0));
        else b.index = (img_cnt == 0) ? '0 : 7'($urandom_range(img_cnt - 1, 0));
      end
      idx = b.index;
      nxt = (b.opcode == OP_INSERT) ? idx : idx + 1;
      lo  = (idx > 0 && idx <= img_cnt) ? img_keys[idx - 1] : '0;
      hi  = (nxt < img_cnt) ? img_keys[nxt] : '1;
      case (op_t'(b.opcode))
        OP_INSERT, OP_WRITE: begin
          // keep order, with repeats of the lower neighbor now and then
          if ($urandom_range(4) == 0) b.key = lo;
          else b.key = $urandom_range(hi, lo);
        end
        OP_SRCH_UP, OP_SRCH_EQ, OP_SRCH_LE: begin
          if (img_cnt > 0 && $urandom_range(3) != 0)
            b.key = img_keys[$urandom_range(img_cnt - 1, 0)] + $urandom_range(2) - 1;
        end
        OP_SET_COUNT: b.new_count = 7'($urandom_range(defined_run(), 0));
        default: ;
      endcase
    end
    if (b.opcode == OP_SET_COUNT && b.new_count <= MAX_KEYS && b.new_count > defined_run())
      b.new_count = 7'($urandom_range(127, MAX_KEYS + 1));
    return b;
  endfunction

  task automatic send(in_beat_t b);
    while (!(n_sent >= 600 && n_sent < 760) && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    img_apply(b);
    n_sent++;
  endtask

  // receiver: random stalls, one long hold-off, and a calm stretch
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    out_stall <= 1'b0;
    n_got     <= 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) n_got <= n_got + 1;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!held && n_got >= 400) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (n_got >= 600 && n_got < 760) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 12);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    img_cnt  = 0;
    img_set  = '0;
    grow     = 1'b1;
    n_sent   = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty node: refused read and remove, searches, count loads
    send(cmd(OP_READ, 32'd0, 0, 0));
    send(cmd(OP_REMOVE, 32'd0, 0, 0));
    send(cmd(OP_SRCH_UP, 32'hFFFF_FFFF, 0, 0));
    send(cmd(OP_SRCH_EQ, 32'd0, 0, 0));
    send(cmd(OP_SRCH_LE, 32'd0, 0, 0));
    send(cmd(OP_SET_COUNT, 32'd0, 0, 0));
    send(cmd(OP_SET_COUNT, 32'd0, 0, MAX_KEYS + 1));
    send(cmd(OP_SET_COUNT, 32'd0, 0, 127));
    // insert past the end, then build 0, 100, 100, max
    send(cmd(OP_INSERT, 32'd5, 1, 0));
    send(cmd(OP_INSERT, 32'd100, 0, 0));
    send(cmd(OP_INSERT, 32'hFFFF_FFFF, 1, 0));
    send(cmd(OP_INSERT, 32'd0, 0, 0));
    send(cmd(OP_INSERT, 32'd100, 2, 0));
    send(cmd(OP_SRCH_UP, 32'd100, 0, 0));
    send(cmd(OP_SRCH_EQ, 32'd100, 0, 0));
    send(cmd(OP_SRCH_LE, 32'd100, 0, 0));
    send(cmd(OP_SRCH_EQ, 32'd50, 0, 0));
    send(cmd(OP_SRCH_LE, 32'd50, 0, 0));
    send(cmd(OP_READ, 32'd0, 3, 0));
    send(cmd(OP_READ, 32'd0, 4, 0));
    send(cmd(OP_WRITE, 32'd50, 1, 0));
    send(cmd(OP_WRITE, 32'd7, 4, 0));
    send(cmd(OP_REMOVE, 32'd0, 3, 0));
    send(cmd(OP_REMOVE, 32'd0, 5, 0));
    // the removed top cell still holds its key, so the count may cover it
    send(cmd(OP_SET_COUNT, 32'd0, 0, 4));

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == 300) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (n_got < n_sent);
      end
      send(make_beat());
    end
    in_valid <= 1'b0;
    do @(posedge clk); while (n_got < n_sent);
    repeat (10) @(posedge clk);
    if (fails == 0 && waiting == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
